### design/lcs_length_three_sequences_assert.svh
// Assertion macros shared by the longest common subsequence block.
// Every macro expects clk_i and rst_ni to be in scope.
`ifndef LCS_LENGTH_THREE_SEQUENCES_ASSERT_SVH
`define LCS_LENGTH_THREE_SEQUENCES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCS3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcs3 assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCS3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcs3 assertion failed");

`endif

### design/lcs3_pkg.sv
`timescale 1ns / 1ps

package lcs3_pkg;

  localparam int MaxLen     = 16;
  localparam int NumSeq     = 3;
  localparam int ElemW      = 32;
  localparam int LenW       = 5;
  localparam int IdxW       = $clog2(MaxLen + 1);
  localparam int StoreAw    = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int SeqW       = $clog2(NumSeq);
  localparam int PlaneDim   = MaxLen + 1;
  localparam int PlaneCells = PlaneDim * PlaneDim;
  localparam int PlaneDepth = 2 * PlaneCells;
  localparam int PlaneAw    = $clog2(PlaneDepth);

  typedef enum logic [1:0] {
    ReqAppendX = 2'd0,
    ReqAppendY = 2'd1,
    ReqAppendZ = 2'd2,
    ReqCompute = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    EngIdle,
    EngRd1,
    EngRd2,
    EngWr,
    EngDone
  } eng_state_e;

  typedef struct packed {
    logic [StoreAw-1:0] x_idx;
    logic [StoreAw-1:0] y_idx;
    logic [StoreAw-1:0] z_idx;
  } store_rd_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] len;
  } eng_result_t;

  function automatic logic [PlaneAw-1:0] plane_addr(logic            plane,
                                                    logic [IdxW-1:0] row,
                                                    logic [IdxW-1:0] col);
    logic [PlaneAw-1:0] base;
    base = plane ? PlaneAw'(PlaneCells) : '0;
    return base + PlaneAw'(row) * PlaneAw'(PlaneDim) + PlaneAw'(col);
  endfunction

endpackage

### design/lcs3_seq_store.sv
`timescale 1ns / 1ps

module lcs3_seq_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [1:0]                          req_type_i,
  input  logic [lcs3_pkg::ElemW-1:0]          elem_value_i,
  input  logic                                clear_i,
  input  lcs3_pkg::store_rd_t                 rd_i,
  output logic [lcs3_pkg::ElemW-1:0]          x_val_o,
  output logic [lcs3_pkg::ElemW-1:0]          y_val_o,
  output logic [lcs3_pkg::ElemW-1:0]          z_val_o,
  output logic [lcs3_pkg::IdxW-1:0]           count_x_o,
  output logic [lcs3_pkg::IdxW-1:0]           count_y_o,
  output logic [lcs3_pkg::IdxW-1:0]           count_z_o,
  output logic                                dropped_o
);

  logic [lcs3_pkg::ElemW-1:0] store_q [lcs3_pkg::NumSeq][lcs3_pkg::MaxLen];
  logic [lcs3_pkg::IdxW-1:0]  count_q [lcs3_pkg::NumSeq];
  logic [lcs3_pkg::IdxW-1:0]  count_d [lcs3_pkg::NumSeq];
  logic                       dropped_q, dropped_d;
  logic [lcs3_pkg::SeqW-1:0]  sel;
  logic                       has_room;

  assign sel      = lcs3_pkg::SeqW'(req_type_i);
  assign has_room = count_q[sel] < lcs3_pkg::IdxW'(lcs3_pkg::MaxLen);

  always_comb begin
    for (int s = 0; s < lcs3_pkg::NumSeq; s++) begin
      count_d[s] = count_q[s];
    end
    dropped_d = dropped_q;
    if (clear_i) begin
      for (int s = 0; s < lcs3_pkg::NumSeq; s++) begin
        count_d[s] = '0;
      end
      dropped_d = 1'b0;
    end else if (wr_en_i) begin
      if (has_room) begin
        count_d[sel] = count_q[sel] + lcs3_pkg::IdxW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < lcs3_pkg::NumSeq; s++) begin
        count_q[s] <= '0;
      end
      dropped_q <= 1'b0;
    end else begin
      for (int s = 0; s < lcs3_pkg::NumSeq; s++) begin
        count_q[s] <= count_d[s];
      end
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clear_i && has_room) begin
      store_q[sel][count_q[sel][lcs3_pkg::StoreAw-1:0]] <= elem_value_i;
    end
  end

  assign x_val_o   = store_q[0][rd_i.x_idx];
  assign y_val_o   = store_q[1][rd_i.y_idx];
  assign z_val_o   = store_q[2][rd_i.z_idx];
  assign count_x_o = count_q[0];
  assign count_y_o = count_q[1];
  assign count_z_o = count_q[2];
  assign dropped_o = dropped_q;

endmodule

### design/lcs3_plane_ram.sv
`timescale 1ns / 1ps

module lcs3_plane_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [lcs3_pkg::PlaneAw-1:0]  wr_addr_i,
  input  logic [lcs3_pkg::IdxW-1:0]     wr_data_i,
  input  logic [lcs3_pkg::PlaneAw-1:0]  rd_addr_a_i,
  input  logic [lcs3_pkg::PlaneAw-1:0]  rd_addr_b_i,
  output logic [lcs3_pkg::IdxW-1:0]     rd_data_a_o,
  output logic [lcs3_pkg::IdxW-1:0]     rd_data_b_o
);

  logic [lcs3_pkg::IdxW-1:0] mem [lcs3_pkg::PlaneDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

### design/lcs3_engine.sv
`timescale 1ns / 1ps
`include "lcs_length_three_sequences_assert.svh"

module lcs3_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               ack_i,
  input  logic [lcs3_pkg::IdxW-1:0]          count_x_i,
  input  logic [lcs3_pkg::IdxW-1:0]          count_y_i,
  input  logic [lcs3_pkg::IdxW-1:0]          count_z_i,
  input  logic [lcs3_pkg::ElemW-1:0]         x_val_i,
  input  logic [lcs3_pkg::ElemW-1:0]         y_val_i,
  input  logic [lcs3_pkg::ElemW-1:0]         z_val_i,
  output lcs3_pkg::store_rd_t                rd_o,
  output logic                               busy_o,
  output lcs3_pkg::eng_result_t              result_o
);

  lcs3_pkg::eng_state_e state_q, state_d;

  logic [lcs3_pkg::IdxW-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic [lcs3_pkg::IdxW-1:0]    prev_q, prev_d, up_q, up_d, last_q, last_d;
  logic [lcs3_pkg::IdxW-1:0]    im1, jm1, km1;
  logic [lcs3_pkg::IdxW-1:0]    diag, left, max_pu, max3, cell_val;
  logic                         any_empty, match, last_cell;
  logic                         cur_plane, prev_plane;
  logic                         ram_we;
  logic [lcs3_pkg::PlaneAw-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [lcs3_pkg::IdxW-1:0]    rd_data_a, rd_data_b;

  assign im1        = i_q - lcs3_pkg::IdxW'(1);
  assign jm1        = j_q - lcs3_pkg::IdxW'(1);
  assign km1        = k_q - lcs3_pkg::IdxW'(1);
  assign cur_plane  = i_q[0];
  assign prev_plane = ~i_q[0];
  assign any_empty  = (count_x_i == '0) || (count_y_i == '0) || (count_z_i == '0);
  assign last_cell  = (k_q == count_z_i) && (j_q == count_y_i) && (i_q == count_x_i);

  assign rd_o.x_idx = im1[lcs3_pkg::StoreAw-1:0];
  assign rd_o.y_idx = jm1[lcs3_pkg::StoreAw-1:0];
  assign rd_o.z_idx = km1[lcs3_pkg::StoreAw-1:0];

  assign match    = (x_val_i == y_val_i) && (y_val_i == z_val_i);
  assign diag     = ((i_q == lcs3_pkg::IdxW'(1)) || (j_q == lcs3_pkg::IdxW'(1)) ||
                     (k_q == lcs3_pkg::IdxW'(1))) ? '0 : rd_data_a;
  assign left     = (k_q == lcs3_pkg::IdxW'(1)) ? '0 : last_q;
  assign max_pu   = (prev_q > up_q) ? prev_q : up_q;
  assign max3     = (max_pu > left) ? max_pu : left;
  assign cell_val = match ? diag + lcs3_pkg::IdxW'(1) : max3;

  lcs3_plane_ram u_plane_ram (
    .clk_i       (clk_i),
    .we_i        (ram_we),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (cell_val),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcs3_pkg::EngIdle: begin
        if (start_i) begin
          state_d = any_empty ? lcs3_pkg::EngDone : lcs3_pkg::EngRd1;
        end
      end
      lcs3_pkg::EngRd1: state_d = lcs3_pkg::EngRd2;
      lcs3_pkg::EngRd2: state_d = lcs3_pkg::EngWr;
      lcs3_pkg::EngWr:  state_d = last_cell ? lcs3_pkg::EngDone : lcs3_pkg::EngRd1;
      lcs3_pkg::EngDone: begin
        if (ack_i) begin
          state_d = lcs3_pkg::EngIdle;
        end
      end
      default: state_d = lcs3_pkg::EngIdle;
    endcase
  end

  always_comb begin
    rd_addr_a = lcs3_pkg::plane_addr(prev_plane, j_q, k_q);
    rd_addr_b = lcs3_pkg::plane_addr(cur_plane, jm1, k_q);
    wr_addr   = lcs3_pkg::plane_addr(cur_plane, j_q, k_q);
    ram_we    = 1'b0;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    prev_d    = prev_q;
    up_d      = up_q;
    last_d    = last_q;
    unique case (state_q)
      lcs3_pkg::EngIdle: begin
        if (start_i) begin
          i_d    = lcs3_pkg::IdxW'(1);
          j_d    = lcs3_pkg::IdxW'(1);
          k_d    = lcs3_pkg::IdxW'(1);
          last_d = '0;
        end
      end
      lcs3_pkg::EngRd1: begin
      end
      lcs3_pkg::EngRd2: begin
        rd_addr_a = lcs3_pkg::plane_addr(prev_plane, jm1, km1);
        prev_d    = (i_q == lcs3_pkg::IdxW'(1)) ? '0 : rd_data_a;
        up_d      = (j_q == lcs3_pkg::IdxW'(1)) ? '0 : rd_data_b;
      end
      lcs3_pkg::EngWr: begin
        ram_we = 1'b1;
        last_d = cell_val;
        if (k_q < count_z_i) begin
          k_d = k_q + lcs3_pkg::IdxW'(1);
        end else begin
          k_d = lcs3_pkg::IdxW'(1);
          if (j_q < count_y_i) begin
            j_d = j_q + lcs3_pkg::IdxW'(1);
          end else begin
            j_d = lcs3_pkg::IdxW'(1);
            if (i_q < count_x_i) begin
              i_d = i_q + lcs3_pkg::IdxW'(1);
            end
          end
        end
      end
      lcs3_pkg::EngDone: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs3_pkg::EngIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    up_q   <= up_d;
    last_q <= last_d;
  end

  assign busy_o         = state_q != lcs3_pkg::EngIdle;
  assign result_o.valid = state_q == lcs3_pkg::EngDone;
  assign result_o.len   = last_q;

  `LCS3_ASSERT_NEXT(a_wr_continues, state_q == lcs3_pkg::EngWr, (state_q == lcs3_pkg::EngRd1) || (state_q == lcs3_pkg::EngDone))
  `LCS3_ASSERT_IMP(a_k_in_range, state_q == lcs3_pkg::EngRd1, (k_q != '0) && (k_q <= count_z_i))
  `LCS3_ASSERT_IMP(a_cell_bounded, state_q == lcs3_pkg::EngWr, cell_val <= i_q)
  `LCS3_ASSERT_NEXT(a_done_release, (state_q == lcs3_pkg::EngDone) && ack_i, state_q == lcs3_pkg::EngIdle)

endmodule

### design/lcs_length_three_sequences.sv
// Longest common subsequence length of three sequences. Each input beat either appends
// one 32-bit element to sequence X, Y or Z (up to 16 each; further elements are dropped
// and reported through overflow_flag) or requests a computation, which returns one result
// beat and then empties all three sequences. Appends are taken one per cycle while in_stall_o
// is low. A compute request holds in_stall_o high until its result moves into the output
// register, and longer while an earlier result still waits unaccepted in that register:
// the engine steps one table cell at a time, through states EngRd1, EngRd2 and EngWr for
// each cell, through a dual-read plane memory, and the result waits in an output register
// so that appends may continue.
`timescale 1ns / 1ps

module lcs_length_three_sequences (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic signed [lcs3_pkg::ElemW-1:0]  elem_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lcs3_pkg::LenW-1:0]          lcs_length_o,
  output logic                               overflow_flag_o
);

  logic                          in_accept, start, append, take;
  logic                          busy, dropped;
  lcs3_pkg::store_rd_t           store_rd;
  lcs3_pkg::eng_result_t         result;
  logic [lcs3_pkg::ElemW-1:0]    x_val, y_val, z_val;
  logic [lcs3_pkg::IdxW-1:0]     count_x, count_y, count_z;
  logic                          out_valid_q;
  logic [lcs3_pkg::LenW-1:0]     lcs_length_q;
  logic                          overflow_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign start     = in_accept && (req_type_i == lcs3_pkg::ReqCompute);
  assign append    = in_accept && (req_type_i != lcs3_pkg::ReqCompute);
  assign take      = result.valid && (!out_valid_q || !out_stall_i);

  lcs3_seq_store u_seq_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (append),
    .req_type_i   (req_type_i),
    .elem_value_i (elem_value_i),
    .clear_i      (take),
    .rd_i         (store_rd),
    .x_val_o      (x_val),
    .y_val_o      (y_val),
    .z_val_o      (z_val),
    .count_x_o    (count_x),
    .count_y_o    (count_y),
    .count_z_o    (count_z),
    .dropped_o    (dropped)
  );

  lcs3_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .ack_i     (take),
    .count_x_i (count_x),
    .count_y_i (count_y),
    .count_z_i (count_z),
    .x_val_i   (x_val),
    .y_val_i   (y_val),
    .z_val_i   (z_val),
    .rd_o      (store_rd),
    .busy_o    (busy),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      lcs_length_q <= result.len[lcs3_pkg::LenW-1:0];
      overflow_q   <= dropped;
    end
  end

  assign in_stall_o      = busy;
  assign out_valid_o     = out_valid_q;
  assign lcs_length_o    = lcs_length_q;
  assign overflow_flag_o = overflow_q;

endmodule
